>>> rtl/gdd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and calendar tables for the Gregorian date difference core.
// No dependencies; used by gdd_date and gregorian_date_difference_core.
package gdd_pkg;

    localparam int DAY_W     = 5;
    localparam int MONTH_W   = 4;
    localparam int YEAR_W    = 14;
    localparam int ORD_W     = 22;
    localparam int MAX_YEAR  = 9999;

    // Per-date results handed from the date unit to the top level
    typedef struct packed {
        logic                 valid;
        logic [ORD_W-1:0]     ordinal;
        logic [DAY_W-1:0]     month_len;
    } gdd_date_info_t;

    // Month length in a common year; codes outside 1..12 give zero
    function automatic logic [DAY_W-1:0] month_len_common(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:                                       len = 5'd28;
                default:                                    len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Days in a common year before the first of month m
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] n;
        begin
            unique case (m)
                4'd2:    n = 9'd31;
                4'd3:    n = 9'd59;
                4'd4:    n = 9'd90;
                4'd5:    n = 9'd120;
                4'd6:    n = 9'd151;
                4'd7:    n = 9'd181;
                4'd8:    n = 9'd212;
                4'd9:    n = 9'd243;
                4'd10:   n = 9'd273;
                4'd11:   n = 9'd304;
                4'd12:   n = 9'd334;
                default: n = 9'd0;
            endcase
            return n;
        end
    endfunction

endpackage

>>> rtl/gdd_date.sv
`timescale 1ns / 1ps
// Per-date unit: validity check, month length and day ordinal counted from 1 January of year 0.
// Depends on gdd_pkg.
module gdd_date
(
    input  logic [gdd_pkg::DAY_W-1:0]   day,
    input  logic [gdd_pkg::MONTH_W-1:0] month,
    input  logic [gdd_pkg::YEAR_W-1:0]  year,
    output gdd_pkg::gdd_date_info_t     info
);

    logic [26:0]                   q_prod;
    logic [7:0]                    q100;
    logic [13:0]                   rem_full;
    logic [6:0]                    r100;
    logic                          r100_nz;
    logic                          leap;
    logic [7:0]                    ceil100;
    logic [6:0]                    ceil400;
    logic [12:0]                   ceil4;
    logic [14:0]                   y_plus3;
    logic [gdd_pkg::ORD_W-1:0]     year_days;
    logic [gdd_pkg::DAY_W-1:0]     mlen;
    logic                          month_ok;

    // year / 100 by reciprocal multiply, exact for all 14-bit years
    assign q_prod   = 27'(year) * 27'(5243);
    assign q100     = q_prod[26:19];
    assign rem_full = 14'(year - 14'(q100) * 14'(100));
    assign r100     = rem_full[6:0];
    assign r100_nz  = (r100 != 7'd0);

    assign leap = ((year[1:0] == 2'b00) && r100_nz) || (!r100_nz && (q100[1:0] == 2'b00));

    assign y_plus3 = 15'(year) + 15'd3;
    assign ceil4   = y_plus3[14:2];
    assign ceil100 = q100 + 8'(r100_nz);
    assign ceil400 = 7'(q100[7:2]) + 7'(r100_nz || (q100[1:0] != 2'b00));

    assign year_days = gdd_pkg::ORD_W'(year) * gdd_pkg::ORD_W'(365)
                     + gdd_pkg::ORD_W'(ceil4)
                     - gdd_pkg::ORD_W'(ceil100)
                     + gdd_pkg::ORD_W'(ceil400);

    assign mlen = gdd_pkg::month_len_common(month) + 5'((month == 4'd2) && leap);

    assign month_ok = (month >= 4'd1) && (month <= 4'd12);

    assign info.month_len = mlen;
    assign info.valid     = month_ok && (year <= 14'(gdd_pkg::MAX_YEAR))
                         && (day != 5'd0) && (day <= mlen);
    assign info.ordinal   = year_days
                          + gdd_pkg::ORD_W'(gdd_pkg::days_before(month))
                          + gdd_pkg::ORD_W'(leap && (month > 4'd2))
                          + gdd_pkg::ORD_W'(day);

endmodule

>>> rtl/gregorian_date_difference_core.sv
`timescale 1ns / 1ps
// Gregorian date difference core: two-stage pipeline from an input register to a result register.
// Depends on gdd_pkg and gdd_date.
//
// Takes one pair of Gregorian dates per transaction and returns, one result per pair, the whole-day
// distance between them, a year/month/day difference (day borrow uses the earlier date's month
// length, month borrow takes twelve), and flags for swapped order, equal dates and invalid input.
// A pair is accepted every cycle while the result side keeps up; each pair passes through the
// input register, then the result register, before its result is presented on the outputs, and
// the whole calculation sits between those two registers. An invalid date zeroes every other
// result field.
module gregorian_date_difference_core
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [gdd_pkg::DAY_W-1:0]       first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]     first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]      first_year,
    input  logic [gdd_pkg::DAY_W-1:0]       second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]     second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]      second_year,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [gdd_pkg::ORD_W-1:0]       day_distance,
    output logic [gdd_pkg::YEAR_W-1:0]      diff_years,
    output logic [3:0]                      diff_months,
    output logic [4:0]                      diff_days,
    output logic                            were_swapped,
    output logic                            dates_equal,
    output logic                            date_invalid
);

    // input register
    logic                               s1_valid_reg;
    logic [gdd_pkg::DAY_W-1:0]          d1_reg, d2_reg;
    logic [gdd_pkg::MONTH_W-1:0]        m1_reg, m2_reg;
    logic [gdd_pkg::YEAR_W-1:0]         y1_reg, y2_reg;

    // result register
    logic                               out_valid_reg;
    logic [gdd_pkg::ORD_W-1:0]          dist_reg, dist_next;
    logic [gdd_pkg::YEAR_W-1:0]         dy_reg, dy_next;
    logic [3:0]                         dm_reg, dm_next;
    logic [4:0]                         dd_reg, dd_next;
    logic                               swap_reg, swap_next;
    logic                               equal_reg, equal_next;
    logic                               inval_reg, inval_next;

    logic                               out_free;
    logic                               s1_move;
    logic                               in_take;

    gdd_pkg::gdd_date_info_t            info1, info2;

    logic                               swap;
    logic [gdd_pkg::DAY_W-1:0]          lo_d, hi_d, lo_len;
    logic [gdd_pkg::MONTH_W-1:0]        lo_m, hi_m;
    logic [gdd_pkg::YEAR_W-1:0]         lo_y, hi_y;
    logic [gdd_pkg::ORD_W-1:0]          ord_lo, ord_hi;
    logic signed [6:0]                  dd_raw, dd_fix;
    logic signed [5:0]                  dm_raw, dm_fix;
    logic signed [14:0]                 dy_raw, dy_fix;

    gdd_date u_date1
    (
        .day   (d1_reg),
        .month (m1_reg),
        .year  (y1_reg),
        .info  (info1)
    );

    gdd_date u_date2
    (
        .day   (d2_reg),
        .month (m2_reg),
        .year  (y2_reg),
        .info  (info2)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        swap   = (info1.ordinal > info2.ordinal);
        lo_d   = swap ? d2_reg : d1_reg;
        lo_m   = swap ? m2_reg : m1_reg;
        lo_y   = swap ? y2_reg : y1_reg;
        hi_d   = swap ? d1_reg : d2_reg;
        hi_m   = swap ? m1_reg : m2_reg;
        hi_y   = swap ? y1_reg : y2_reg;
        lo_len = swap ? info2.month_len : info1.month_len;
        ord_lo = swap ? info2.ordinal : info1.ordinal;
        ord_hi = swap ? info1.ordinal : info2.ordinal;

        dd_raw = $signed({2'b00, hi_d}) - $signed({2'b00, lo_d});
        dm_raw = $signed({2'b00, hi_m}) - $signed({2'b00, lo_m});
        dy_raw = $signed({1'b0, hi_y}) - $signed({1'b0, lo_y});

        // borrow the earlier month's length, then twelve months
        dd_fix = dd_raw;
        dm_fix = dm_raw;
        if (dd_raw < 0)
        begin
            dd_fix = dd_raw + $signed({2'b00, lo_len});
            dm_fix = dm_raw - 6'sd1;
        end
        dy_fix = dy_raw;
        if (dm_fix < 0)
        begin
            dm_fix = dm_fix + 6'sd12;
            dy_fix = dy_raw - 15'sd1;
        end

        dist_next  = '0;
        dy_next    = '0;
        dm_next    = '0;
        dd_next    = '0;
        swap_next  = 1'b0;
        equal_next = 1'b0;
        inval_next = 1'b0;

        priority if (!info1.valid || !info2.valid)
        begin
            inval_next = 1'b1;
        end
        else if (info1.ordinal == info2.ordinal)
        begin
            equal_next = 1'b1;
        end
        else
        begin
            swap_next = swap;
            dist_next = ord_hi - ord_lo;
            dy_next   = dy_fix[13:0];
            dm_next   = dm_fix[3:0];
            dd_next   = dd_fix[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take || s1_move)
            begin
                s1_valid_reg <= in_take;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            d1_reg <= first_day;
            m1_reg <= first_month;
            y1_reg <= first_year;
            d2_reg <= second_day;
            m2_reg <= second_month;
            y2_reg <= second_year;
        end
        if (s1_move)
        begin
            dist_reg  <= dist_next;
            dy_reg    <= dy_next;
            dm_reg    <= dm_next;
            dd_reg    <= dd_next;
            swap_reg  <= swap_next;
            equal_reg <= equal_next;
            inval_reg <= inval_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign day_distance = dist_reg;
    assign diff_years   = dy_reg;
    assign diff_months  = dm_reg;
    assign diff_days    = dd_reg;
    assign were_swapped = swap_reg;
    assign dates_equal  = equal_reg;
    assign date_invalid = inval_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked result");

    a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dates_equal) |-> (day_distance == '0 && !were_swapped && !date_invalid))
        else $error("equal dates with non-zero difference");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && date_invalid) |-> (day_distance == '0 && !were_swapped && !dates_equal))
        else $error("invalid dates with non-zero result");

    a_months_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (diff_months <= 4'd11 && diff_days <= 5'd30))
        else $error("calendar difference out of range");

    a_swap_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && were_swapped) |-> (day_distance != '0))
        else $error("swapped dates with zero distance");

endmodule

>>> tb/gregorian_date_difference_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for gregorian_date_difference_core: directed and random date pairs.
// Each transaction's result is predicted in-bench and checked in order. Depends on gdd_pkg.
module gregorian_date_difference_core_tb;

    typedef struct packed {
        logic [gdd_pkg::DAY_W-1:0]   day;
        logic [gdd_pkg::MONTH_W-1:0] month;
        logic [gdd_pkg::YEAR_W-1:0]  year;
    } cal_date_t;

    typedef struct packed {
        logic [gdd_pkg::ORD_W-1:0]  day_distance;
        logic [gdd_pkg::YEAR_W-1:0] diff_years;
        logic [3:0]                 diff_months;
        logic [4:0]                 diff_days;
        logic                       were_swapped;
        logic                       dates_equal;
        logic                       date_invalid;
    } date_gap_t;

    logic                         clk;
    logic                         rst_n        = 1'b0;
    logic                         in_valid     = 1'b0;
    logic                         in_stall;
    logic [gdd_pkg::DAY_W-1:0]    first_day    = '0;
    logic [gdd_pkg::MONTH_W-1:0]  first_month  = '0;
    logic [gdd_pkg::YEAR_W-1:0]   first_year   = '0;
    logic [gdd_pkg::DAY_W-1:0]    second_day   = '0;
    logic [gdd_pkg::MONTH_W-1:0]  second_month = '0;
    logic [gdd_pkg::YEAR_W-1:0]   second_year  = '0;
    logic                         out_valid;
    logic                         out_stall    = 1'b0;
    logic [gdd_pkg::ORD_W-1:0]    day_distance;
    logic [gdd_pkg::YEAR_W-1:0]   diff_years;
    logic [3:0]                   diff_months;
    logic [4:0]                   diff_days;
    logic                         were_swapped;
    logic                         dates_equal;
    logic                         date_invalid;

    date_gap_t pending_gaps[$];
    int        in_idle_pct    = 0;
    int        out_stall_pct  = 0;
    int        error_count    = 0;
    int        pairs_sent     = 0;
    int        pairs_checked  = 0;
    int        invalid_seen   = 0;
    int        equal_seen     = 0;
    int        swapped_seen   = 0;

    gregorian_date_difference_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_day    (first_day),
        .first_month  (first_month),
        .first_year   (first_year),
        .second_day   (second_day),
        .second_month (second_month),
        .second_year  (second_year),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .day_distance (day_distance),
        .diff_years   (diff_years),
        .diff_months  (diff_months),
        .diff_days    (diff_days),
        .were_swapped (were_swapped),
        .dates_equal  (dates_equal),
        .date_invalid (date_invalid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- calendar arithmetic

    function automatic bit is_leap(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic bit date_ok(cal_date_t c);
        return (int'(c.year) <= gdd_pkg::MAX_YEAR) && (c.month >= 1) && (c.month <= 12)
            && (c.day >= 1) && (int'(c.day) <= int'(month_days(c.month, c.year)));
    endfunction

    // Day count from 1 January of year 0, which counts as day 1
    function automatic int unsigned day_number(cal_date_t c);
        int unsigned y;
        int unsigned n;
        y = c.year;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + c.day;
        for (int unsigned k = 1; k < c.month; k++)
            n += month_days(k, y);
        return n;
    endfunction

    function automatic date_gap_t predict_gap(cal_date_t a, cal_date_t b);
        date_gap_t   r;
        cal_date_t   lo;
        cal_date_t   hi;
        int unsigned na;
        int unsigned nb;
        int          dy;
        int          dm;
        int          dd;
        r = '0;
        if (!date_ok(a) || !date_ok(b))
        begin
            r.date_invalid = 1'b1;
            return r;
        end
        na = day_number(a);
        nb = day_number(b);
        if (na == nb)
        begin
            r.dates_equal = 1'b1;
            return r;
        end
        if (na > nb)
        begin
            r.were_swapped = 1'b1;
            lo = b;
            hi = a;
            r.day_distance = gdd_pkg::ORD_W'(na - nb);
        end
        else
        begin
            lo = a;
            hi = b;
            r.day_distance = gdd_pkg::ORD_W'(nb - na);
        end
        dy = int'(hi.year) - int'(lo.year);
        dm = int'(hi.month) - int'(lo.month);
        dd = int'(hi.day) - int'(lo.day);
        // borrow the earlier date's month length, then twelve months
        if (dd < 0)
        begin
            dm--;
            dd += int'(month_days(lo.month, lo.year));
        end
        if (dm < 0)
        begin
            dy--;
            dm += 12;
        end
        r.diff_years  = gdd_pkg::YEAR_W'(dy);
        r.diff_months = 4'(dm);
        r.diff_days   = 5'(dd);
        return r;
    endfunction

    // ---------------------------------------------------------------- date generators

    function automatic cal_date_t dmy(int d, int m, int y);
        cal_date_t c;
        c.day   = gdd_pkg::DAY_W'(d);
        c.month = gdd_pkg::MONTH_W'(m);
        c.year  = gdd_pkg::YEAR_W'(y);
        return c;
    endfunction

    function automatic cal_date_t any_valid_date();
        cal_date_t c;
        int        sel;
        sel = $urandom_range(99);
        // lean on the ends of the year range now and then
        if (sel < 5)
            c.year = gdd_pkg::YEAR_W'($urandom_range(3));
        else if (sel < 10)
            c.year = gdd_pkg::YEAR_W'(gdd_pkg::MAX_YEAR - $urandom_range(3));
        else
            c.year = gdd_pkg::YEAR_W'($urandom_range(gdd_pkg::MAX_YEAR));
        c.month = gdd_pkg::MONTH_W'($urandom_range(12, 1));
        c.day   = gdd_pkg::DAY_W'($urandom_range(month_days(c.month, c.year), 1));
        return c;
    endfunction

    function automatic cal_date_t nearby_date(cal_date_t a);
        cal_date_t c;
        int        y;
        c = a;
        case ($urandom_range(3))
            0: ;
            1: c.month = gdd_pkg::MONTH_W'($urandom_range(12, 1));
            2: ;
            default:
            begin
                y = int'(a.year) + int'($urandom_range(2)) - 1;
                if (y < 0)
                    y = 0;
                if (y > gdd_pkg::MAX_YEAR)
                    y = gdd_pkg::MAX_YEAR;
                c.year  = gdd_pkg::YEAR_W'(y);
                c.month = gdd_pkg::MONTH_W'($urandom_range(12, 1));
            end
        endcase
        if (c != a || $urandom_range(1) == 1)
            c.day = gdd_pkg::DAY_W'($urandom_range(month_days(c.month, c.year), 1));
        return c;
    endfunction

    function automatic cal_date_t raw_date();
        cal_date_t c;
        c.day   = gdd_pkg::DAY_W'($urandom);
        c.month = gdd_pkg::MONTH_W'($urandom);
        c.year  = gdd_pkg::YEAR_W'($urandom);
        return c;
    endfunction

    // ---------------------------------------------------------------- drive and check

    // Hold the payload until accepted; leave valid high for a back-to-back follower
    task automatic send_pair(cal_date_t a, cal_date_t b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        first_day    <= a.day;
        first_month  <= a.month;
        first_year   <= a.year;
        second_day   <= b.day;
        second_month <= b.month;
        second_year  <= b.year;
        pending_gaps.push_back(predict_gap(a, b));
        pairs_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
    begin
        date_gap_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_gaps.size() == 0)
            begin
                $error("result transaction with no pair outstanding");
                error_count++;
            end
            else
            begin
                want = pending_gaps.pop_front();
                pairs_checked++;
                if (want.date_invalid)
                    invalid_seen++;
                if (want.dates_equal)
                    equal_seen++;
                if (want.were_swapped)
                    swapped_seen++;
                if (day_distance !== want.day_distance)
                begin
                    $error("day_distance: expected %0d, got %0d", want.day_distance, day_distance);
                    error_count++;
                end
                if (diff_years !== want.diff_years)
                begin
                    $error("diff_years: expected %0d, got %0d", want.diff_years, diff_years);
                    error_count++;
                end
                if (diff_months !== want.diff_months)
                begin
                    $error("diff_months: expected %0d, got %0d", want.diff_months, diff_months);
                    error_count++;
                end
                if (diff_days !== want.diff_days)
                begin
                    $error("diff_days: expected %0d, got %0d", want.diff_days, diff_days);
                    error_count++;
                end
                if (were_swapped !== want.were_swapped)
                begin
                    $error("were_swapped: expected %0d, got %0d", want.were_swapped, were_swapped);
                    error_count++;
                end
                if (dates_equal !== want.dates_equal)
                begin
                    $error("dates_equal: expected %0d, got %0d", want.dates_equal, dates_equal);
                    error_count++;
                end
                if (date_invalid !== want.date_invalid)
                begin
                    $error("date_invalid: expected %0d, got %0d", want.date_invalid, date_invalid);
                    error_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    task automatic test_field_extremes();
        send_pair(dmy(1, 1, 0), dmy(31, 12, gdd_pkg::MAX_YEAR));
        send_pair(dmy(31, 12, gdd_pkg::MAX_YEAR), dmy(1, 1, 0));
        send_pair(dmy(0, 5, 2000), dmy(1, 1, 2000));
        send_pair(dmy(1, 0, 2000), dmy(1, 1, 2000));
        send_pair(dmy(31, 15, 16383), dmy(31, 15, 16383));
        send_pair(dmy(1, 1, 10000), dmy(1, 1, 2000));
        send_pair(dmy(1, 1, 2000), dmy(31, 4, 2000));
    endtask

    task automatic test_leap_year_rules();
        send_pair(dmy(29, 2, 2000), dmy(1, 3, 2000));
        send_pair(dmy(29, 2, 1900), dmy(1, 1, 1900));
        send_pair(dmy(29, 2, 2024), dmy(28, 2, 2023));
        send_pair(dmy(1, 1, 2023), dmy(29, 2, 2023));
        send_pair(dmy(29, 2, 0), dmy(1, 3, 0));
        send_pair(dmy(31, 12, 1999), dmy(1, 1, 2001));
    endtask

    task automatic test_ordering_and_equality();
        send_pair(dmy(15, 6, 2020), dmy(15, 6, 2020));
        send_pair(dmy(29, 2, 2000), dmy(29, 2, 2000));
        send_pair(dmy(2, 1, 2020), dmy(1, 1, 2020));
        send_pair(dmy(1, 2, 2020), dmy(31, 1, 2020));
        send_pair(dmy(31, 12, 2019), dmy(1, 1, 2020));
    endtask

    task automatic test_calendar_borrows();
        send_pair(dmy(31, 1, 2021), dmy(1, 3, 2021));
        send_pair(dmy(1, 3, 2025), dmy(29, 2, 2024));
        send_pair(dmy(15, 11, 2020), dmy(10, 2, 2021));
        send_pair(dmy(31, 12, 2020), dmy(1, 1, 2021));
    endtask

    // Mostly valid pairs, many close together; the rest broken or raw noise
    task automatic run_random_pairs(int count);
        cal_date_t a;
        cal_date_t b;
        cal_date_t t;
        int        sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            a = any_valid_date();
            if (sel < 50)
                b = any_valid_date();
            else if (sel < 80)
                b = nearby_date(a);
            else if (sel < 90)
                b = raw_date();
            else
            begin
                a = raw_date();
                b = raw_date();
            end
            if ($urandom_range(1) == 1)
            begin
                t = a;
                a = b;
                b = t;
            end
            send_pair(a, b);
        end
    endtask

    task automatic test_random_back_pressure();
        in_idle_pct   = 18;
        out_stall_pct = 70;
        run_random_pairs(310);
    endtask

    task automatic test_random_sparse_input();
        in_idle_pct   = 70;
        out_stall_pct = 18;
        run_random_pairs(310);
    endtask

    task automatic test_random_streaming();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        run_random_pairs(310);
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_field_extremes();
        test_leap_year_rules();
        test_ordering_and_equality();
        test_calendar_borrows();
        test_random_back_pressure();
        test_random_sparse_input();
        test_random_streaming();

        in_valid      <= 1'b0;
        out_stall_pct = 0;
        while (pending_gaps.size() != 0)
            @(negedge clk);
        // catch any stray result behind the two-stage pipeline
        repeat (8) @(negedge clk);

        $display("Sent %0d date pairs, checked %0d results (%0d invalid, %0d equal, %0d swapped)",
                 pairs_sent, pairs_checked, invalid_seen, equal_seen, swapped_seen);
        $display("Covered input idling, output back-pressure and full-rate streaming");
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/gdd_pkg.sv
rtl/gdd_date.sv
rtl/gregorian_date_difference_core.sv
tb/gregorian_date_difference_core_tb.sv
